[rtl/core/drb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drb_pkg: shared types and constants of the damped resonator bank
// Word layouts, register indexes, fixed-point widths and the command bundle
// that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package drb_pkg;

  // parameter defaults
  localparam int CHANNELS_DEF     = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // field widths
  localparam int IDX_W      = 6;   // channel index field
  localparam int COEF_W     = 32;  // Q2.30 coefficient
  localparam int SMP_W      = 16;  // sample field
  localparam int POS_W      = 48;  // Q16.32 state
  localparam int GAIN_W     = 32;  // Q0.32 input gain
  localparam int ACT_W      = 7;   // active channel count register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // multiplier: state magnitude times one 16-bit coefficient half
  localparam int HALF_W  = 16;
  localparam int PROD_W  = POS_W + HALF_W;
  localparam int MACC_W  = POS_W + COEF_W;   // full magnitude product
  localparam int FRAC_SH = 30;
  localparam int TERM_W  = MACC_W - FRAC_SH + 2;

  localparam logic [MACC_W-1:0] RND_HALF = MACC_W'(1) << (FRAC_SH - 1);

  localparam logic signed [POS_W-1:0] ST_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [POS_W-1:0] ST_MIN = 48'sh8000_0000_0000;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd2;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         channel;
    logic [COEF_W-1:0]        damping_coef;
    logic [COEF_W-1:0]        stiffness_coef;
    logic signed [SMP_W-1:0]  sample_left;
    logic signed [SMP_W-1:0]  sample_right;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_channel;
    logic signed [POS_W-1:0]  position;
    logic                     last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic             load;    // coefficient write from input word
    logic             sample;  // latch drive from input word
    logic             rd;      // read stores at idx, seed accumulators
    logic             mul;     // one partial product
    logic [1:0]       phase;   // [1] stiffness side, [0] low half
    logic             acc;     // fold registered product
    logic             term;    // signed damping + stiffness terms
    logic             vel;     // new velocity
    logic             pos;     // new position, write back, load output
    logic             last;
    logic [IDX_W-1:0] idx;
  } cmd_t;

endpackage

[rtl/core/drb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drb_ctrl: sequencer of the resonator bank
// Accepts words, walks the active channels and steps the shared datapath
// through read, four multiply passes, drain, term, velocity and position.
// ----------------------------------------------------------------------------
module drb_ctrl import drb_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_kind,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cmd_t                  cmd
);

  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_DRAIN, ST_TERM, ST_VEL, ST_POS
  } state_t;

  state_t            state;
  logic [1:0]        phase;
  logic [CH_AW-1:0]  idx;
  logic [CNT_W-1:0]  count;
  logic [ACT_W-1:0]  active;

  logic              accept;
  logic              out_free;
  logic              last;
  logic [CNT_W-1:0]  n_eff;

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign n_eff    = (active > ACT_W'(CHANNELS)) ? CNT_W'(CHANNELS) : CNT_W'(active);
  assign last     = (CNT_W'(idx) + CNT_W'(1)) == count;

  always_comb begin
    cmd        = '0;
    cmd.load   = accept && (in_kind == KIND_LOAD);
    cmd.sample = accept && (in_kind == KIND_SAMPLE);
    cmd.rd     = (state == ST_READ);
    cmd.mul    = (state == ST_MUL);
    cmd.acc    = ((state == ST_MUL) && (phase != 2'd0)) || (state == ST_DRAIN);
    cmd.phase  = phase;
    cmd.term   = (state == ST_TERM);
    cmd.vel    = (state == ST_VEL);
    cmd.pos    = (state == ST_POS) && out_free;
    cmd.last   = last;
    cmd.idx    = IDX_W'(idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= 2'd0;
      idx       <= '0;
      count     <= '0;
      active    <= ACTIVE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write && (cfg_index == REG_ACTIVE)) begin
        active <= cfg_data[ACT_W-1:0];
      end
      if (cmd.pos) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.sample && (n_eff != '0)) begin
            count <= n_eff;
            idx   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          phase <= 2'd0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_TERM;
        ST_TERM:  state <= ST_VEL;
        ST_VEL:   state <= ST_POS;
        ST_POS: begin
          if (out_free) begin
            if (last) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + CH_AW'(1);
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/drb_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drb_dp: resonator datapath
// State and coefficient memories, drive product, shared 48x16 multiplier
// with rounding accumulators, saturating velocity and position update.
// ----------------------------------------------------------------------------
module drb_dp import drb_pkg::*; #(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  in_word_t              in_word,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output out_word_t             out_word
);

  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RAW_W = (SAMPLE_WIDTH > SMP_W) ? SAMPLE_WIDTH : SMP_W;
  localparam int DRV_W = SAMPLE_WIDTH + GAIN_W + 1;
  localparam int SUM_W = ((DRV_W > TERM_W) ? DRV_W : TERM_W) + 2;

  // configuration
  logic               target;
  logic [GAIN_W-1:0]  gain;

  // stores
  logic signed [POS_W-1:0] vel_mem   [CHANNELS];
  logic signed [POS_W-1:0] pos_mem   [CHANNELS];
  logic [COEF_W-1:0]       damp_mem  [CHANNELS];
  logic [COEF_W-1:0]       stiff_mem [CHANNELS];
  logic [CHANNELS-1:0]     st_valid;

  // registered read data
  logic signed [POS_W-1:0] rd_u, rd_x;
  logic [COEF_W-1:0]       rd_cd, rd_ks;
  logic                    rd_valid;

  // working registers
  logic signed [DRV_W-1:0]  drive_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     prod_hi;
  logic                     prod_stiff;
  logic [MACC_W-1:0]        acc_d, acc_s;
  logic signed [TERM_W-1:0] tsum_r;
  logic signed [POS_W-1:0]  vel_new;
  out_word_t                out_r;

  // combinational
  logic [CH_AW-1:0]          addr;
  logic [CH_AW-1:0]          ch_addr;
  logic                      ch_ok;
  logic [SMP_W-1:0]          sel;
  logic [RAW_W-1:0]          raw;
  logic signed [SAMPLE_WIDTH-1:0] smp;
  logic signed [GAIN_W:0]    gain_s;
  logic signed [DRV_W-1:0]   drive_next;
  logic signed [POS_W-1:0]   u_op, x_op;
  logic [POS_W-1:0]          mag_u, mag_x, mag_sel;
  logic [HALF_W-1:0]         half;
  logic [PROD_W-1:0]         prod_next;
  logic [MACC_W-1:0]         addend;
  logic [TERM_W-1:0]         tm_d, tm_s;
  logic signed [TERM_W-1:0]  td, ts;
  logic signed [SUM_W-1:0]   vsum;
  logic signed [POS_W-1:0]   vel_sat;
  logic signed [POS_W:0]     xsum;
  logic signed [POS_W-1:0]   pos_sat;

  assign addr    = cmd.idx[CH_AW-1:0];
  assign ch_addr = in_word.channel[CH_AW-1:0];
  assign ch_ok   = ({1'b0, in_word.channel} < (IDX_W + 1)'(CHANNELS));

  // sample select and drive = sample * gain, exact
  assign sel        = target ? $unsigned(in_word.sample_right) : $unsigned(in_word.sample_left);
  assign raw        = RAW_W'(sel);
  assign smp        = $signed(raw[SAMPLE_WIDTH-1:0]);
  assign gain_s     = $signed({1'b0, gain});
  assign drive_next = smp * gain_s;

  // unwritten state entries read as zero
  assign u_op  = rd_valid ? rd_u : '0;
  assign x_op  = rd_valid ? rd_x : '0;
  assign mag_u = u_op[POS_W-1] ? $unsigned(-u_op) : $unsigned(u_op);
  assign mag_x = x_op[POS_W-1] ? $unsigned(-x_op) : $unsigned(x_op);

  always_comb begin
    mag_sel = cmd.phase[1] ? mag_x : mag_u;
    case (cmd.phase)
      2'd0:    half = rd_cd[COEF_W-1:HALF_W];
      2'd1:    half = rd_cd[HALF_W-1:0];
      2'd2:    half = rd_ks[COEF_W-1:HALF_W];
      default: half = rd_ks[HALF_W-1:0];
    endcase
  end

  assign prod_next = mag_sel * half;
  assign addend    = prod_hi ? {prod_r, {HALF_W{1'b0}}} : {{HALF_W{1'b0}}, prod_r};

  // rounded magnitudes, sign restored
  assign tm_d = TERM_W'(acc_d[MACC_W-1:FRAC_SH]);
  assign tm_s = TERM_W'(acc_s[MACC_W-1:FRAC_SH]);
  assign td   = u_op[POS_W-1] ? -$signed(tm_d) : $signed(tm_d);
  assign ts   = x_op[POS_W-1] ? -$signed(tm_s) : $signed(tm_s);

  assign vsum = SUM_W'(u_op) + SUM_W'(drive_r) - SUM_W'(tsum_r);
  always_comb begin
    if (vsum > SUM_W'(ST_MAX)) begin
      vel_sat = ST_MAX;
    end else if (vsum < SUM_W'(ST_MIN)) begin
      vel_sat = ST_MIN;
    end else begin
      vel_sat = vsum[POS_W-1:0];
    end
  end

  assign xsum = (POS_W + 1)'(x_op) + (POS_W + 1)'(vel_new);
  always_comb begin
    if (xsum > (POS_W + 1)'(ST_MAX)) begin
      pos_sat = ST_MAX;
    end else if (xsum < (POS_W + 1)'(ST_MIN)) begin
      pos_sat = ST_MIN;
    end else begin
      pos_sat = xsum[POS_W-1:0];
    end
  end

  // configuration and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      target   <= 1'b0;
      gain     <= '0;
      st_valid <= '0;
    end else begin
      if (cfg_write && (cfg_index == REG_TARGET)) begin
        target <= cfg_data[0];
      end
      if (cfg_write && (cfg_index == REG_GAIN)) begin
        gain <= cfg_data[GAIN_W-1:0];
      end
      if (cmd.pos) begin
        st_valid[addr] <= 1'b1;
      end
    end
  end

  // coefficient memories
  always_ff @(posedge clk) begin
    if (cmd.load && ch_ok) begin
      damp_mem[ch_addr]  <= in_word.damping_coef;
      stiff_mem[ch_addr] <= in_word.stiffness_coef;
    end
    if (cmd.rd) begin
      rd_cd <= damp_mem[addr];
      rd_ks <= stiff_mem[addr];
    end
  end

  // state memories
  always_ff @(posedge clk) begin
    if (cmd.pos) begin
      vel_mem[addr] <= vel_new;
      pos_mem[addr] <= pos_sat;
    end
    if (cmd.rd) begin
      rd_u     <= vel_mem[addr];
      rd_x     <= pos_mem[addr];
      rd_valid <= st_valid[addr];
    end
  end

  // arithmetic pipeline
  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      drive_r <= drive_next;
    end
    if (cmd.mul) begin
      prod_r     <= prod_next;
      prod_hi    <= ~cmd.phase[0];
      prod_stiff <= cmd.phase[1];
    end
    if (cmd.rd) begin
      acc_d <= RND_HALF;
      acc_s <= RND_HALF;
    end else if (cmd.acc) begin
      if (prod_stiff) begin
        acc_s <= acc_s + addend;
      end else begin
        acc_d <= acc_d + addend;
      end
    end
    if (cmd.term) begin
      tsum_r <= td + ts;
    end
    if (cmd.vel) begin
      vel_new <= vel_sat;
    end
    if (cmd.pos) begin
      out_r.out_channel <= cmd.idx;
      out_r.position    <= pos_sat;
      out_r.last        <= cmd.last;
    end
  end

  assign out_word = out_r;

endmodule

[rtl/core/damped_resonator_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_resonator_bank: bank of damped spring resonators
// Semi-implicit Euler step of every active resonator per audio sample,
// Q2.30 coefficients, Q16.32 saturating velocity and position.
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake             word
//   -----------  ----  --------------------  --------------------------------
//   in_*         in    in_valid / in_stall   load (coefs) or audio sample
//   out_*        out   out_valid / out_stall one position per active channel
//   cfg_*        in    cfg_write             target, gain, active count
//
// A load word writes the coefficients of an in-range channel. A sample word
// starts a run over the active channels, each stepped through read, four
// multiply passes, drain, term, velocity and position. The run length is
// set by the single shared 48x16 multiplier, which makes four passes for the
// damping and stiffness products of each channel.
// Reset is synchronous, active high; it zeroes the state stores through per
// entry valid bits, so no clearing pass is needed after reset.
// in_stall is high while a sample run is in progress. An output register
// holds each result; a stalled result holds the run at that channel.
//
module damped_resonator_bank import drb_pkg::*; #(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;

  // sequencer: handshakes, channel walk, step commands
  drb_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_kind   (in_word.kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd)
  );

  // datapath: stores, multiplier, update arithmetic, output register
  drb_dp #(
    .CHANNELS     (CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  // a new result only follows a position write-back
  a_out_from_pos: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.pos))
    else $error("result appeared without a write-back");

  // no step of a run is under way while a word is taken
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !(cmd.rd || cmd.mul || cmd.acc || cmd.pos))
    else $error("word accepted during a channel step");

  // a load word never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_word.kind == KIND_LOAD) && !out_valid)
    |=> !out_valid)
    else $error("load word produced a result");
`endif

endmodule
